@@ rtl/aht_pkg.sv @@
package aht_pkg;

   // Table geometry (ENTRIES must be a power of two)
   localparam int ENTRIES    = 256;
   localparam int SLOT_W     = $clog2(ENTRIES);
   localparam int CNT_W      = 9;

   // Name layout
   localparam int NAME_CHARS = 11;
   localparam int HEAD_BYTES = 6;
   localparam int TAIL_BYTES = 5;
   localparam int HEAD_W     = 8 * HEAD_BYTES;
   localparam int TAIL_W     = 8 * TAIL_BYTES;

   // Tag layout: age on top of the hash
   localparam int HASH_W     = 22;
   localparam int AGE_W      = 8;
   localparam int TAG_W      = HASH_W + AGE_W;

   // Start slot arithmetic
   localparam int H10_W      = 10;
   localparam int MULT_W     = 5;
   localparam int PROD_W     = H10_W + MULT_W;
   localparam int START_MULT = 23;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(40);

   // Lookup hash kinds; every other code acts as the full hash
   localparam logic [1:0] KIND_H12 = 2'd1;
   localparam logic [1:0] KIND_H10 = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_AGE    = 2'd1,
      CMD_ADD    = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_DONE      = 3'd0,
      STS_INSERTED  = 3'd1,
      STS_REFRESHED = 3'd2,
      STS_FULL      = 3'd3,
      STS_FOUND     = 3'd4,
      STS_MISS      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

   // Valid-bit array control
   typedef struct packed {
      logic              clear_all;
      logic              set_en;
      logic              drop_en;
      logic [SLOT_W-1:0] slot;
   } vctl_type;

   // Memory port control
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_slot;
      logic              name_we;
      logic              tag_we;
      logic [SLOT_W-1:0] wr_slot;
      logic [TAG_W-1:0]  tag_wdata;
   } mctl_type;

   // Home slot of a 10-bit hash part
   function automatic logic [SLOT_W-1:0] start_slot(input logic [H10_W-1:0] h10);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(h10) * PROD_W'(START_MULT);
      return prod[SLOT_W-1:0];
   endfunction

endpackage

@@ rtl/aht_ram.sv @@
module aht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/aht_canon.sv @@
module aht_canon
   import aht_pkg::*;
(
   input  logic [HEAD_W-1:0] in_head,
   input  logic [TAIL_W-1:0] in_tail,
   output logic [HEAD_W-1:0] out_head,
   output logic [TAIL_W-1:0] out_tail
);

   // Zero every byte from the first zero byte on, and past the name limit
   always_comb begin
      logic       ended;
      logic [7:0] b;
      ended    = 1'b0;
      out_head = '0;
      out_tail = '0;
      for (int i = 0; i < HEAD_BYTES + TAIL_BYTES; i++) begin
         if (i < HEAD_BYTES) begin
            b = in_head[8*(HEAD_BYTES-1-i) +: 8];
         end else begin
            b = in_tail[8*(HEAD_BYTES+TAIL_BYTES-1-i) +: 8];
         end
         if (b == 8'd0 || i >= NAME_CHARS) begin
            ended = 1'b1;
         end
         if (ended) begin
            b = 8'd0;
         end
         if (i < HEAD_BYTES) begin
            out_head[8*(HEAD_BYTES-1-i) +: 8] = b;
         end else begin
            out_tail[8*(HEAD_BYTES+TAIL_BYTES-1-i) +: 8] = b;
         end
      end
   end

endmodule

@@ rtl/aht_valid.sv @@
module aht_valid
   import aht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  vctl_type          vctl,
   input  logic [SLOT_W-1:0] look_slot,
   output logic              used,
   output logic [CNT_W-1:0]  used_count
);

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   // Set, drop or clear occupancy
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (vctl.clear_all) begin
         valid_in = '0;
         count_in = '0;
      end else if (vctl.set_en) begin
         valid_in[vctl.slot] = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end else if (vctl.drop_en) begin
         valid_in[vctl.slot] = 1'b0;
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   assign used       = valid_ff[look_slot];
   assign used_count = count_ff;

endmodule

@@ rtl/aht_engine.sv @@
module aht_engine
   import aht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // command beat
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [HASH_W-1:0] req_hash_value,
   input  logic [1:0]        req_hash_kind,
   input  logic [HEAD_W-1:0] req_name_head,
   input  logic [TAIL_W-1:0] req_name_tail,
   // result beat
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [HEAD_W-1:0] rsp_found_head,
   output logic [TAIL_W-1:0] rsp_found_tail,
   output logic [CNT_W-1:0]  rsp_entry_count,
   // register
   input  logic [AGE_W-1:0]  max_age,
   // occupancy
   output vctl_type          vctl,
   output logic [SLOT_W-1:0] look_slot,
   input  logic              used,
   input  logic [CNT_W-1:0]  used_count,
   // memories
   output mctl_type          mctl,
   output logic [HEAD_W-1:0] wr_head,
   output logic [TAIL_W-1:0] wr_tail,
   input  logic [HEAD_W-1:0] rd_head,
   input  logic [TAIL_W-1:0] rd_tail,
   input  logic [TAG_W-1:0]  rd_tag
);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [1:0]        kind_ff, kind_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [TAIL_W-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] probes_ff, probes_in;
   status_type        status_ff, status_in;
   logic [HEAD_W-1:0] fhead_ff, fhead_in;
   logic [TAIL_W-1:0] ftail_ff, ftail_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [HEAD_W-1:0] rsp_fhead_ff, rsp_fhead_in;
   logic [TAIL_W-1:0] rsp_ftail_ff, rsp_ftail_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic              accept;
   logic              rsp_free;
   logic              name_empty;
   logic [H10_W-1:0]  req_h10;
   logic [HASH_W-1:0] st_hash;
   logic [AGE_W-1:0]  st_age;
   logic [HASH_W-1:0] st_hash_shifted;
   logic              add_match;
   logic              look_match;
   logic              last_slot;
   logic              last_probe;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign name_empty = (req_name_head[HEAD_W-1 -: 8] == 8'd0);
   assign st_hash    = rd_tag[HASH_W-1:0];
   assign st_age     = rd_tag[TAG_W-1:HASH_W];
   assign last_slot  = (slot_ff == SLOT_W'(ENTRIES - 1));
   assign last_probe = (probes_ff == SLOT_W'(ENTRIES - 1));

   // Pick the 10-bit part of the hash that sets the home slot
   always_comb begin
      if (cmd_type'(req_cmd) == CMD_LOOKUP && req_hash_kind == KIND_H10) begin
         req_h10 = req_hash_value[H10_W-1:0];
      end else if (cmd_type'(req_cmd) == CMD_LOOKUP && req_hash_kind == KIND_H12) begin
         req_h10 = req_hash_value[H10_W+1:2];
      end else begin
         req_h10 = req_hash_value[HASH_W-1:HASH_W-H10_W];
      end
   end

   // Align the stored hash to the lookup width
   always_comb begin
      if (kind_ff == KIND_H10) begin
         st_hash_shifted = HASH_W'(st_hash[HASH_W-1:12]);
      end else if (kind_ff == KIND_H12) begin
         st_hash_shifted = HASH_W'(st_hash[HASH_W-1:10]);
      end else begin
         st_hash_shifted = st_hash;
      end
   end

   assign add_match  = used && (st_hash == hash_ff) && (rd_head == head_ff)
                       && (rd_tail == tail_ff);
   assign look_match = used && (st_hash_shifted == hash_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR:  state_in = ST_CLEAR;
                  CMD_AGE:    state_in = ST_READ;
                  CMD_ADD:    state_in = name_empty ? ST_FINISH : ST_READ;
                  CMD_LOOKUP: state_in = ST_READ;
               endcase
            end
         end
         ST_CLEAR: state_in = ST_FINISH;
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL: begin
            unique case (cmd_ff)
               CMD_AGE: state_in = last_slot ? ST_FINISH : ST_READ;
               CMD_ADD: begin
                  if (!used || add_match || last_probe) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               CMD_LOOKUP: begin
                  if (!used || look_match || last_probe) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory and occupancy controls
   always_comb begin
      cmd_in        = cmd_ff;
      hash_in       = hash_ff;
      kind_in       = kind_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      slot_in       = slot_ff;
      probes_in     = probes_ff;
      status_in     = status_ff;
      fhead_in      = fhead_ff;
      ftail_in      = ftail_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_fhead_in  = rsp_fhead_ff;
      rsp_ftail_in  = rsp_ftail_ff;
      rsp_count_in  = rsp_count_ff;

      vctl.clear_all = 1'b0;
      vctl.set_en    = 1'b0;
      vctl.drop_en   = 1'b0;
      vctl.slot      = slot_ff;

      mctl.rd_en     = 1'b0;
      mctl.rd_slot   = slot_ff;
      mctl.name_we   = 1'b0;
      mctl.tag_we    = 1'b0;
      mctl.wr_slot   = slot_ff;
      mctl.tag_wdata = {AGE_W'(0), st_hash};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = cmd_type'(req_cmd);
               hash_in   = req_hash_value;
               kind_in   = req_hash_kind;
               head_in   = req_name_head;
               tail_in   = req_name_tail;
               probes_in = '0;
               fhead_in  = '0;
               ftail_in  = '0;
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR:  status_in = STS_DONE;
                  CMD_AGE:    status_in = STS_DONE;
                  CMD_ADD:    status_in = name_empty ? STS_DONE : STS_FULL;
                  CMD_LOOKUP: status_in = STS_MISS;
               endcase
               if (cmd_type'(req_cmd) == CMD_AGE) begin
                  slot_in = '0;
               end else begin
                  slot_in = start_slot(req_h10);
               end
            end
         end
         ST_CLEAR: begin
            vctl.clear_all = 1'b1;
         end
         ST_READ: begin
            mctl.rd_en = 1'b1;
         end
         ST_EVAL: begin
            slot_in   = slot_ff + SLOT_W'(1);
            probes_in = probes_ff + SLOT_W'(1);
            unique case (cmd_ff)
               CMD_AGE: begin
                  // free stale entries, bump the age of the rest
                  if (used) begin
                     if (st_age > max_age) begin
                        vctl.drop_en = 1'b1;
                     end else begin
                        mctl.tag_we    = 1'b1;
                        mctl.tag_wdata = {st_age + AGE_W'(1), st_hash};
                     end
                  end
               end
               CMD_ADD: begin
                  if (!used) begin
                     vctl.set_en    = 1'b1;
                     mctl.name_we   = 1'b1;
                     mctl.tag_we    = 1'b1;
                     mctl.tag_wdata = {AGE_W'(0), hash_ff};
                     status_in      = STS_INSERTED;
                  end else if (add_match) begin
                     mctl.tag_we = 1'b1;
                     status_in   = STS_REFRESHED;
                  end
               end
               CMD_LOOKUP: begin
                  if (look_match) begin
                     fhead_in  = rd_head;
                     ftail_in  = rd_tail;
                     status_in = STS_FOUND;
                  end
               end
               default: ;
            endcase
         end
         ST_FINISH: begin
            // hand the result to the output register
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_fhead_in  = fhead_ff;
               rsp_ftail_in  = ftail_ff;
               rsp_count_in  = used_count;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      hash_ff       <= hash_in;
      kind_ff       <= kind_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      slot_ff       <= slot_in;
      probes_ff     <= probes_in;
      status_ff     <= status_in;
      fhead_ff      <= fhead_in;
      ftail_ff      <= ftail_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fhead_ff  <= rsp_fhead_in;
      rsp_ftail_ff  <= rsp_ftail_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign look_slot       = slot_ff;
   assign wr_head         = head_ff;
   assign wr_tail         = tail_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_head  = rsp_fhead_ff;
   assign rsp_found_tail  = rsp_ftail_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

@@ rtl/aging_hash_name_table.sv @@
// Hash table of up to 256 names (11 characters each) with a 22-bit hash and
// an 8-bit age per entry, open addressing with linear probing. Commands:
// clear, age sweep, add and lookup; each gives one result beat with a status,
// the name found by a lookup and the entry count. Names, tags and ages sit in
// memories with a registered read port; every probed slot goes through a read
// state and an evaluate/write-back state, and an age sweep visits all 256
// slots. The next command beat is taken while a result beat still waits at
// the output. Occupancy lives in flip-flops, so reset and clear take effect
// at once with no clearing pass. max_age is written through the csr port and
// is used by every later age evaluation, also within a sweep in progress.
module aging_hash_name_table
   import aht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [HASH_W-1:0] req_hash_value,
   input  logic [1:0]        req_hash_kind,
   input  logic [HEAD_W-1:0] req_name_head,
   input  logic [TAIL_W-1:0] req_name_tail,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [HEAD_W-1:0] rsp_found_head,
   output logic [TAIL_W-1:0] rsp_found_tail,
   output logic [CNT_W-1:0]  rsp_entry_count,
   // register write channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [AGE_W-1:0]  csr_max_age
);

   logic [AGE_W-1:0]  max_age_ff;
   logic [AGE_W-1:0]  max_age_in;
   logic [HEAD_W-1:0] canon_head;
   logic [TAIL_W-1:0] canon_tail;
   vctl_type          vctl;
   mctl_type          mctl;
   logic [SLOT_W-1:0] look_slot;
   logic              used;
   logic [CNT_W-1:0]  used_count;
   logic [HEAD_W-1:0] wr_head;
   logic [TAIL_W-1:0] wr_tail;
   logic [HEAD_W-1:0] rd_head;
   logic [TAIL_W-1:0] rd_tail;
   logic [TAG_W-1:0]  rd_tag;
   logic [HEAD_W+TAIL_W-1:0] rd_name;

   // Hold the age limit
   assign csr_ready  = 1'b1;
   assign max_age_in = (csr_valid && csr_ready) ? csr_max_age : max_age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MAX_AGE_RESET;
      end else begin
         max_age_ff <= max_age_in;
      end
   end

   aht_canon u_canon (
      .in_head  (req_name_head),
      .in_tail  (req_name_tail),
      .out_head (canon_head),
      .out_tail (canon_tail)
   );

   aht_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_hash_value  (req_hash_value),
      .req_hash_kind   (req_hash_kind),
      .req_name_head   (canon_head),
      .req_name_tail   (canon_tail),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_head  (rsp_found_head),
      .rsp_found_tail  (rsp_found_tail),
      .rsp_entry_count (rsp_entry_count),
      .max_age         (max_age_ff),
      .vctl            (vctl),
      .look_slot       (look_slot),
      .used            (used),
      .used_count      (used_count),
      .mctl            (mctl),
      .wr_head         (wr_head),
      .wr_tail         (wr_tail),
      .rd_head         (rd_head),
      .rd_tail         (rd_tail),
      .rd_tag          (rd_tag)
   );

   aht_valid u_valid (
      .clock      (clock),
      .reset      (reset),
      .vctl       (vctl),
      .look_slot  (look_slot),
      .used       (used),
      .used_count (used_count)
   );

   // Name memory: head characters on top of tail characters
   aht_ram #(.WIDTH(HEAD_W + TAIL_W), .DEPTH(ENTRIES)) u_name_ram (
      .clock (clock),
      .we    (mctl.name_we),
      .waddr (mctl.wr_slot),
      .wdata ({wr_head, wr_tail}),
      .re    (mctl.rd_en),
      .raddr (mctl.rd_slot),
      .rdata (rd_name)
   );

   assign rd_head = rd_name[HEAD_W+TAIL_W-1:TAIL_W];
   assign rd_tail = rd_name[TAIL_W-1:0];

   aht_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
      .clock (clock),
      .we    (mctl.tag_we),
      .waddr (mctl.wr_slot),
      .wdata (mctl.tag_wdata),
      .re    (mctl.rd_en),
      .raddr (mctl.rd_slot),
      .rdata (rd_tag)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import aht_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   typedef struct {
      logic [2:0]        status;
      logic [HEAD_W-1:0] head;
      logic [TAIL_W-1:0] tail;
      logic [CNT_W-1:0]  count;
   } table_reply_type;

   // One command beat; typed rows carry a result that is known by inspection
   typedef struct {
      cmd_type           cmd;
      logic [HASH_W-1:0] hv;
      logic [1:0]        kind;
      logic [HEAD_W-1:0] head;
      logic [TAIL_W-1:0] tail;
      bit                typed;
      status_type        st;
      logic [HEAD_W-1:0] fh;
      logic [TAIL_W-1:0] ft;
      logic [CNT_W-1:0]  cnt;
   } script_row_type;

   typedef struct {
      logic [HEAD_W-1:0] head;
      logic [TAIL_W-1:0] tail;
      logic [HASH_W-1:0] hash;
   } name_entry_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_cmd;
   logic [HASH_W-1:0] req_hash_value;
   logic [1:0]        req_hash_kind;
   logic [HEAD_W-1:0] req_name_head;
   logic [TAIL_W-1:0] req_name_tail;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_status;
   logic [HEAD_W-1:0] rsp_found_head;
   logic [TAIL_W-1:0] rsp_found_tail;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic              csr_valid;
   logic              csr_ready;
   logic [AGE_W-1:0]  csr_max_age;

   aging_hash_name_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_hash_value  (req_hash_value),
      .req_hash_kind   (req_hash_kind),
      .req_name_head   (req_name_head),
      .req_name_tail   (req_name_tail),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_head  (rsp_found_head),
      .rsp_found_tail  (rsp_found_tail),
      .rsp_entry_count (rsp_entry_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_age     (csr_max_age)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the table
   logic [HEAD_W-1:0] slot_head [ENTRIES];
   logic [TAIL_W-1:0] slot_tail [ENTRIES];
   logic [TAG_W-1:0]  slot_tag  [ENTRIES];
   int                live_count;
   logic [AGE_W-1:0]  age_limit = MAX_AGE_RESET;

   table_reply_type replies_due [$];
   name_entry_type  known_names [$];
   int              mismatches = 0;
   int              cycle_count = 0;
   bit              calm = 1'b0;

   // Directed rows, walked once after reset with the reset age limit
   script_row_type directed_rows [19] = '{
      '{CMD_LOOKUP, 22'h0, 2'd0, 48'h0, 40'h0, 1'b1, STS_MISS, 48'h0, 40'h0, 9'd0},
      '{CMD_AGE, 22'h0, 2'd0, 48'h0, 40'h0, 1'b1, STS_DONE, 48'h0, 40'h0, 9'd0},
      '{CMD_ADD, 22'h3FFFFF, 2'd0, 48'h4B3141424300, 40'h0,
        1'b1, STS_INSERTED, 48'h0, 40'h0, 9'd1},
      '{CMD_ADD, 22'h3FFFFF, 2'd0, 48'h4B3141424300, 40'h0,
        1'b1, STS_REFRESHED, 48'h0, 40'h0, 9'd1},
      '{CMD_ADD, 22'h123456, 2'd0, 48'h00FFFFFFFFFF, 40'hFFFFFFFFFF,
        1'b1, STS_DONE, 48'h0, 40'h0, 9'd1},
      '{CMD_ADD, 22'h0, 2'd0, 48'h564B32414243, 40'h4445464748,
        1'b1, STS_INSERTED, 48'h0, 40'h0, 9'd2},
      '{CMD_ADD, 22'h0, 2'd0, 48'h4B3100FFFFFF, 40'hFFFFFFFFFF,
        1'b1, STS_INSERTED, 48'h0, 40'h0, 9'd3},
      '{CMD_ADD, 22'h0, 2'd0, 48'h4B3100000000, 40'h0,
        1'b1, STS_REFRESHED, 48'h0, 40'h0, 9'd3},
      '{CMD_LOOKUP, 22'h3FFFFF, 2'd0, 48'h0, 40'h0,
        1'b1, STS_FOUND, 48'h4B3141424300, 40'h0, 9'd3},
      '{CMD_LOOKUP, 22'h000FFF, 2'd1, 48'h0, 40'h0,
        1'b1, STS_FOUND, 48'h4B3141424300, 40'h0, 9'd3},
      '{CMD_LOOKUP, 22'h0003FF, 2'd2, 48'h0, 40'h0,
        1'b1, STS_FOUND, 48'h4B3141424300, 40'h0, 9'd3},
      '{CMD_LOOKUP, 22'h3FFFFF, 2'd2, 48'h0, 40'h0, 1'b1, STS_MISS, 48'h0, 40'h0, 9'd3},
      '{CMD_LOOKUP, 22'h0, 2'd3, 48'h0, 40'h0,
        1'b1, STS_FOUND, 48'h564B32414243, 40'h4445464748, 9'd3},
      '{CMD_LOOKUP, 22'h1, 2'd0, 48'h0, 40'h0, 1'b1, STS_MISS, 48'h0, 40'h0, 9'd3},
      '{CMD_AGE, 22'h0, 2'd0, 48'h0, 40'h0, 1'b1, STS_DONE, 48'h0, 40'h0, 9'd3},
      '{CMD_LOOKUP, 22'h0, 2'd1, 48'h0, 40'h0, 1'b0, STS_DONE, 48'h0, 40'h0, 9'd0},
      '{CMD_ADD, 22'h155555, 2'd3, 48'h573141570000, 40'h0,
        1'b0, STS_DONE, 48'h0, 40'h0, 9'd0},
      '{CMD_CLEAR, 22'h2AAAAA, 2'd1, 48'hFFFFFFFFFFFF, 40'hFFFFFFFFFF,
        1'b1, STS_DONE, 48'h0, 40'h0, 9'd0},
      '{CMD_LOOKUP, 22'h3FFFFF, 2'd0, 48'h0, 40'h0, 1'b1, STS_MISS, 48'h0, 40'h0, 9'd0}
   };

   // Cut a name at its first zero byte
   function automatic logic [87:0] trimmed(logic [87:0] name);
      bit ended;
      ended = 1'b0;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (name[87-8*i -: 8] == 8'd0)
            ended = 1'b1;
         if (ended)
            name[87-8*i -: 8] = 8'd0;
      end
      return name;
   endfunction

   function automatic int home_slot(logic [H10_W-1:0] h10);
      return (int'(h10) * START_MULT) % ENTRIES;
   endfunction

   function automatic void wipe_slot(int s);
      slot_head[s] = '0;
      slot_tail[s] = '0;
      slot_tag[s]  = '0;
   endfunction

   // Apply one command to the shadow table and return the result beat it gives
   function automatic table_reply_type table_command(cmd_type cmd, logic [HASH_W-1:0] hv,
                                                     logic [1:0] kind,
                                                     logic [HEAD_W-1:0] head_in,
                                                     logic [TAIL_W-1:0] tail_in);
      table_reply_type   r;
      logic [87:0]       name;
      logic [HEAD_W-1:0] head;
      logic [TAIL_W-1:0] tail;
      logic [AGE_W-1:0]  age;
      int                slot;
      int                shift;
      bit                done;
      name = trimmed({head_in, tail_in});
      head = name[87:40];
      tail = name[39:0];
      r.status = STS_DONE;
      r.head = '0;
      r.tail = '0;
      done = 1'b0;
      case (cmd)
         CMD_CLEAR: begin
            for (int s = 0; s < ENTRIES; s++)
               wipe_slot(s);
            live_count = 0;
         end
         CMD_AGE: begin
            for (int s = 0; s < ENTRIES; s++) begin
               if (slot_head[s][HEAD_W-1 -: 8] != 8'd0) begin
                  age = slot_tag[s][TAG_W-1:HASH_W];
                  if (age > age_limit) begin
                     wipe_slot(s);
                     if (live_count > 0)
                        live_count--;
                  end else begin
                     slot_tag[s][TAG_W-1:HASH_W] = age + 1'b1;
                  end
               end
            end
         end
         CMD_ADD: begin
            if (head[HEAD_W-1 -: 8] != 8'd0) begin
               slot = home_slot(hv[HASH_W-1:12]);
               r.status = STS_FULL;
               for (int n = 0; n < ENTRIES && !done; n++) begin
                  if (slot_head[slot][HEAD_W-1 -: 8] == 8'd0) begin
                     slot_head[slot] = head;
                     slot_tail[slot] = tail;
                     slot_tag[slot]  = {{AGE_W{1'b0}}, hv};
                     live_count++;
                     r.status = STS_INSERTED;
                     done = 1'b1;
                  end else if (slot_tag[slot][HASH_W-1:0] == hv && slot_head[slot] == head &&
                               slot_tail[slot] == tail) begin
                     slot_tag[slot][TAG_W-1:HASH_W] = '0;
                     r.status = STS_REFRESHED;
                     done = 1'b1;
                  end else begin
                     slot = (slot + 1) % ENTRIES;
                  end
               end
            end
         end
         default: begin
            // lookup: narrow kinds compare against the top bits of the stored hash
            shift = (kind == KIND_H10) ? 12 : (kind == KIND_H12) ? 10 : 0;
            slot = home_slot(H10_W'(hv >> (12 - shift)));
            r.status = STS_MISS;
            for (int n = 0; n < ENTRIES && !done; n++) begin
               if (slot_head[slot][HEAD_W-1 -: 8] == 8'd0) begin
                  done = 1'b1;
               end else if ((slot_tag[slot][HASH_W-1:0] >> shift) == hv) begin
                  r.status = STS_FOUND;
                  r.head = slot_head[slot];
                  r.tail = slot_tail[slot];
                  done = 1'b1;
               end else begin
                  slot = (slot + 1) % ENTRIES;
               end
            end
         end
      endcase
      r.count = CNT_W'(live_count);
      return r;
   endfunction

   // Random name of 1 to 11 characters, sometimes with junk after the end
   function automatic logic [87:0] random_name();
      logic [87:0] name;
      int          len;
      name = '0;
      len = $urandom_range(1, NAME_CHARS);
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (i < len)
            name[87-8*i -: 8] = 8'($urandom_range(1, 255));
         else if (i > len && $urandom_range(0, 3) == 0)
            name[87-8*i -: 8] = 8'($urandom);
      end
      return name;
   endfunction

   // Half the hashes land on a few home slots so probe chains grow
   function automatic logic [HASH_W-1:0] random_hash();
      logic [HASH_W-1:0] v;
      v = HASH_W'($urandom);
      if ($urandom_range(0, 1) == 1)
         v[HASH_W-1:12] = H10_W'($urandom_range(0, 11));
      return v;
   endfunction

   function automatic script_row_type draw_command(int pct_clear, int pct_age, int pct_add,
                                                   int pct_reuse);
      script_row_type it;
      name_entry_type e;
      logic [87:0]    name;
      int             roll;
      int             pick;
      name = random_name();
      it.head = name[87:40];
      it.tail = name[39:0];
      it.hv = random_hash();
      it.kind = 2'($urandom);
      it.typed = 1'b0;
      it.st = STS_DONE;
      it.fh = '0;
      it.ft = '0;
      it.cnt = '0;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < pct_clear) begin
         it.cmd = CMD_CLEAR;
      end else if (roll < pct_clear + pct_age) begin
         it.cmd = CMD_AGE;
      end else if (roll < pct_clear + pct_age + pct_add) begin
         it.cmd = CMD_ADD;
         if (pick < pct_reuse && known_names.size() > 0) begin
            e = known_names[$urandom_range(0, known_names.size() - 1)];
            it.head = e.head;
            it.tail = e.tail;
            it.hv = e.hash;
         end else if (pick < pct_reuse + 8 && known_names.size() > 0) begin
            e = known_names[$urandom_range(0, known_names.size() - 1)];
            it.head = e.head;
            it.tail = e.tail;
         end else if (pick < pct_reuse + 12) begin
            it.head[HEAD_W-1 -: 8] = 8'd0;
         end
         if (it.head[HEAD_W-1 -: 8] != 8'd0) begin
            e = '{it.head, it.tail, it.hv};
            known_names.insert(known_names.size(), e);
            if (known_names.size() > 48)
               void'(known_names.pop_front());
         end
      end else begin
         it.cmd = CMD_LOOKUP;
         if (pick < 60 && known_names.size() > 0) begin
            e = known_names[$urandom_range(0, known_names.size() - 1)];
            case (it.kind)
               KIND_H10: it.hv = e.hash >> 12;
               KIND_H12: it.hv = e.hash >> 10;
               default:  it.hv = e.hash;
            endcase
         end else if (pick < 80) begin
            it.kind = 2'($urandom_range(1, 2));
            it.hv = (it.kind == KIND_H10) ? it.hv >> 12 : it.hv >> 10;
         end
      end
      return it;
   endfunction

   // Drive one command beat, hold it until taken, then record its result
   task automatic issue_command(script_row_type it);
      table_reply_type want;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= it.cmd;
      req_hash_value <= it.hv;
      req_hash_kind  <= it.kind;
      req_name_head  <= it.head;
      req_name_tail  <= it.tail;
      do @(posedge clock); while (req_stall);
      want = table_command(it.cmd, it.hv, it.kind, it.head, it.tail);
      if (it.typed) begin
         want.status = it.st;
         want.head   = it.fh;
         want.tail   = it.ft;
         want.count  = it.cnt;
      end
      replies_due.insert(replies_due.size(), want);
   endtask

   // Drop valid and wait until every result beat is back
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_age_limit(logic [AGE_W-1:0] value);
      csr_valid   <= 1'b1;
      csr_max_age <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      age_limit = value;
   endtask

   task automatic run_phase(logic [AGE_W-1:0] limit, int beats, int pct_clear, int pct_age,
                            int pct_add, int pct_reuse);
      drain_replies();
      write_age_limit(limit);
      for (int i = 0; i < beats; i++)
         issue_command(draw_command(pct_clear, pct_age, pct_add, pct_reuse));
   endtask

   // Stimulus
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_CLEAR;
      req_hash_value <= '0;
      req_hash_kind  <= '0;
      req_name_head  <= '0;
      req_name_tail  <= '0;
      csr_valid      <= 1'b0;
      csr_max_age    <= '0;
      for (int s = 0; s < ENTRIES; s++)
         wipe_slot(s);
      live_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_command(directed_rows[i]);

      // short lifetime, general mix
      run_phase(8'd3, 380, 2, 15, 45, 35);
      // no expiry, mostly fresh adds until the table is full
      run_phase(8'd255, 360, 0, 0, 90, 4);
      // every aged entry is freed on the next sweep
      run_phase(8'd0, 250, 2, 20, 45, 35);
      // sweep-heavy so surviving ages wrap around
      run_phase(8'd255, 330, 0, 88, 7, 35);
      run_phase(AGE_W'($urandom_range(1, 254)), 360, 3, 12, 45, 35);
      // back-to-back beats on both sides to the end
      drain_replies();
      calm = 1'b1;
      run_phase(AGE_W'($urandom_range(1, 254)), 200, 3, 12, 45, 35);

      drain_replies();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Result stall: random bursts, some followed by a quiet stretch
   int stall_left = 0;
   int quiet_left = 0;
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (quiet_left > 0) begin
         quiet_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0)
            quiet_left = $urandom_range(20, 80);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result beat with the oldest outstanding one
   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("result beat with nothing outstanding, status %0d", rsp_status);
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_found_head !== want.head) begin
               $error("found_head: expected %h, got %h", want.head, rsp_found_head);
               mismatches++;
            end
            if (rsp_found_tail !== want.tail) begin
               $error("found_tail: expected %h, got %h", want.tail, rsp_found_tail);
               mismatches++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               mismatches++;
            end
         end
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

@@ aging_hash_name_table.f @@
rtl/aht_pkg.sv
rtl/aht_ram.sv
rtl/aht_canon.sv
rtl/aht_valid.sv
rtl/aht_engine.sv
rtl/aging_hash_name_table.sv
test/tb_top.sv
